### rtl/core/npc_pkg.sv
// Shared widths, types and register indexes for the nearest point to circle block.
package npc_pkg;

    localparam int COORD_BITS = 16;
    // point minus center, signed, one bit wider than a coordinate
    localparam int DIFF_W = COORD_BITS + 1;
    // squared sum of two magnitudes, kept even so the root has DIFF_W bits
    localparam int SUM_W = 2 * DIFF_W;
    localparam int ROOT_W = SUM_W / 2;
    localparam int DIST_W = COORD_BITS + 1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = COORD_BITS;

    localparam logic [COORD_BITS-1:0] RADIUS_RESET = COORD_BITS'(48);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0] radius_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [DIFF_W-1:0] mag_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } cfg_idx_t;

    // one judged point on its way from the distance unit to the compare stage
    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   start_new;
        dist_t  distance;
    } job_t;

    // handshake between queue and its neighbors
    typedef struct packed {
        logic valid;
        job_t job;
    } job_xfer_t;

endpackage

### rtl/core/npc_point_if.sv
// Input channel carrying one point per transfer.
interface npc_point_if;
    logic             valid;
    logic             ready;
    npc_pkg::coord_t  point_x;
    npc_pkg::coord_t  point_y;
    logic             start_new;

    modport source (output valid, output point_x, output point_y, output start_new,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input start_new,
                  output ready);
endinterface

### rtl/core/npc_best_if.sv
// Output channel carrying the current best point per transfer.
interface npc_best_if;
    logic             valid;
    logic             ready;
    npc_pkg::coord_t  best_x;
    npc_pkg::coord_t  best_y;
    npc_pkg::dist_t   best_distance;
    logic             replaced;

    modport source (output valid, output best_x, output best_y, output best_distance,
                    output replaced, input ready);
    modport sink (input valid, input best_x, input best_y, input best_distance,
                  input replaced, output ready);
endinterface

### rtl/core/nearest_point_to_circle.sv
// Top level: nearest point to a configured circle, running minimum.
//
//  channel    dir  payload                                       transfer when
//  point_in   in   point_x, point_y, start_new                   valid && ready
//  best_out   out  best_x, best_y, best_distance, replaced       valid && ready
//  cfg        in   cfg_index, cfg_data                           cfg_we
//
// A point goes through the front end in steps: capture, square, add, 17
// square root steps (one result bit each) and a push into the queue. The
// square root is serial, and one point is in the front at a time.
// The compare stage updates the best as it pops the queue.
// Reset clears the store, the queue and the result register; no sweep.
// A stalled output fills the queue, then holds the front end.
module nearest_point_to_circle (
    input  logic                            clk,
    input  logic                            rst_n,
    npc_point_if.sink                       point_in,
    npc_best_if.source                      best_out,
    input  logic                            cfg_we,
    input  logic [npc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    npc_pkg::coord_t    center_x_reg, center_y_reg;
    npc_pkg::radius_t   radius_reg;
    npc_pkg::job_xfer_t front_job, queue_job;
    logic               front_ready, back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= npc_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npc_pkg::CFG_CENTER_X: center_x_reg <= npc_pkg::coord_t'(cfg_data);
                npc_pkg::CFG_CENTER_Y: center_y_reg <= npc_pkg::coord_t'(cfg_data);
                npc_pkg::CFG_RADIUS:   radius_reg   <= npc_pkg::radius_t'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    npc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_in  (point_in),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius    (radius_reg),
        .job_out   (front_job),
        .job_ready (front_ready)
    );

    npc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_job),
        .push_ready (front_ready),
        .pop        (queue_job),
        .pop_ready  (back_ready)
    );

    npc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_in    (queue_job),
        .job_ready (back_ready),
        .best_out  (best_out)
    );

endmodule

### rtl/core/npc_front.sv
// Front end: accepts a point and works out its distance to the circle.
module npc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    npc_point_if.sink            point_in,
    input  npc_pkg::coord_t      center_x,
    input  npc_pkg::coord_t      center_y,
    input  npc_pkg::radius_t     radius,
    output npc_pkg::job_xfer_t   job_out,
    input  logic                 job_ready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_ROOT = 5'b01000,
        S_PUSH = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;

    npc_pkg::coord_t px_reg, py_reg;
    logic            start_reg;
    npc_pkg::mag_t   ax_reg, ay_reg;
    npc_pkg::sum_t   sx_reg, sy_reg;
    npc_pkg::sum_t   rem_reg, root_reg, bit_reg;

    logic signed [npc_pkg::DIFF_W-1:0] dx, dy;
    npc_pkg::mag_t  ax, ay;
    npc_pkg::sum_t  trial;
    logic [npc_pkg::ROOT_W-1:0] root_final;
    logic [npc_pkg::ROOT_W-1:0] rad_ext;

    assign dx = $signed({point_in.point_x[npc_pkg::COORD_BITS-1], point_in.point_x})
              - $signed({center_x[npc_pkg::COORD_BITS-1], center_x});
    assign dy = $signed({point_in.point_y[npc_pkg::COORD_BITS-1], point_in.point_y})
              - $signed({center_y[npc_pkg::COORD_BITS-1], center_y});
    assign ax = dx[npc_pkg::DIFF_W-1] ? npc_pkg::mag_t'(-dx) : npc_pkg::mag_t'(dx);
    assign ay = dy[npc_pkg::DIFF_W-1] ? npc_pkg::mag_t'(-dy) : npc_pkg::mag_t'(dy);

    assign trial = root_reg + bit_reg;
    assign root_final = root_reg[npc_pkg::ROOT_W-1:0];
    assign rad_ext = npc_pkg::ROOT_W'(radius);

    assign point_in.ready = (state_reg == S_IDLE);

    always_comb
    begin
        job_out.valid          = (state_reg == S_PUSH);
        job_out.job.point_x    = px_reg;
        job_out.job.point_y    = py_reg;
        job_out.job.start_new  = start_reg;
        job_out.job.distance   = (root_final >= rad_ext)
                               ? npc_pkg::dist_t'(root_final - rad_ext)
                               : npc_pkg::dist_t'(rad_ext - root_final);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (point_in.valid) state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_ROOT;
            S_ROOT: if (bit_reg[0]) state_next = S_PUSH;
            S_PUSH: if (job_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (point_in.valid)
                begin
                    px_reg    <= point_in.point_x;
                    py_reg    <= point_in.point_y;
                    start_reg <= point_in.start_new;
                    ax_reg    <= ax;
                    ay_reg    <= ay;
                end
            end
            S_MUL:
            begin
                sx_reg <= npc_pkg::SUM_W'(ax_reg) * npc_pkg::SUM_W'(ax_reg);
                sy_reg <= npc_pkg::SUM_W'(ay_reg) * npc_pkg::SUM_W'(ay_reg);
            end
            S_SUM:
            begin
                rem_reg  <= sx_reg + sy_reg;
                root_reg <= '0;
                bit_reg  <= npc_pkg::sum_t'(1) << (npc_pkg::SUM_W - 2);
            end
            S_ROOT:
            begin
                // one result bit per cycle, restoring square root
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/npc_queue.sv
// Two-entry queue between the distance front end and the compare stage.
module npc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  npc_pkg::job_xfer_t  push,
    output logic                push_ready,
    output npc_pkg::job_xfer_t  pop,
    input  logic                pop_ready
);

    npc_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push.valid && push_ready;
    assign pop.valid  = (count_reg != 2'd0);
    assign pop.job    = entry_reg[rd_ptr_reg];
    assign do_pop     = pop.valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) entry_reg[wr_ptr_reg] <= push.job;
    end

endmodule

### rtl/core/npc_back.sv
// Back end: keeps the running best and drives the result register.
module npc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  npc_pkg::job_xfer_t  job_in,
    output logic                job_ready,
    npc_best_if.source          best_out
);

    logic            best_valid_reg;
    npc_pkg::coord_t best_x_reg, best_y_reg;
    npc_pkg::dist_t  best_dist_reg;
    logic            out_valid_reg;
    logic            replaced_reg;
    logic            take;

    assign job_ready = !out_valid_reg || best_out.ready;
    assign take = job_in.job.start_new || !best_valid_reg
               || (job_in.job.distance < best_dist_reg);

    assign best_out.valid         = out_valid_reg;
    assign best_out.best_x        = best_x_reg;
    assign best_out.best_y        = best_y_reg;
    assign best_out.best_distance = best_dist_reg;
    assign best_out.replaced      = replaced_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_dist_reg  <= '0;
            replaced_reg   <= 1'b0;
        end
        else
        begin
            if (job_in.valid && job_ready)
            begin
                out_valid_reg <= 1'b1;
                replaced_reg  <= take;
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                    best_x_reg     <= job_in.job.point_x;
                    best_y_reg     <= job_in.job.point_y;
                    best_dist_reg  <= job_in.job.distance;
                end
            end
            else if (best_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### test/tb_nearest_point_to_circle.sv
// Stream testbench for nearest_point_to_circle: random points and stalls, checked per transfer.
`timescale 1ns / 1ps

module tb_nearest_point_to_circle;
    import npc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   start_new;
    } point_t;

    typedef struct {
        coord_t x;
        coord_t y;
        dist_t  distance;
        logic   replaced;
    } best_rec_t;

    logic clk;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    npc_point_if point_in();
    npc_best_if best_out();

    nearest_point_to_circle uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_in  (point_in),
        .best_out  (best_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // circle settings as the block holds them
    coord_t  circle_cx = '0;
    coord_t  circle_cy = '0;
    radius_t circle_r = RADIUS_RESET;

    // running best as predicted
    logic   held_valid = 1'b0;
    coord_t held_x = '0;
    coord_t held_y = '0;
    dist_t  held_dist = '0;

    point_t    point_queue[$];
    best_rec_t best_expected[$];
    point_t    next_point;
    point_t    last_point;
    best_rec_t want;
    int        error_count = 0;
    int        send_gap_left = 0;
    int        sink_hold_left = 0;
    int        cycle_count = 0;
    bit        quiet_phase = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic dist_t circle_gap(coord_t px, coord_t py);
        longint dx;
        longint dy;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned rad;
        dx = longint'(px) - longint'(circle_cx);
        dy = longint'(py) - longint'(circle_cy);
        sq = dx * dx + dy * dy;
        // floor root, one result bit at a time from the top
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        rad = longint'(circle_r);
        return dist_t'((root >= rad) ? root - rad : rad - root);
    endfunction

    function automatic best_rec_t judge_point(point_t p);
        best_rec_t res;
        dist_t d;
        d = circle_gap(p.x, p.y);
        if (p.start_new)
            held_valid = 1'b0;
        res.replaced = !held_valid || (d < held_dist);
        if (res.replaced)
        begin
            held_x = p.x;
            held_y = p.y;
            held_dist = d;
            held_valid = 1'b1;
        end
        res.x = held_x;
        res.y = held_y;
        res.distance = held_dist;
        return res;
    endfunction

    function automatic int send_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(10, 30);
        return $urandom_range(40, 80);
    endfunction

    function automatic int sink_stall();
        int r;
        if (quiet_phase || $urandom_range(0, 99) >= 6)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 95)
            return $urandom_range(5, 30);
        return $urandom_range(60, 120);
    endfunction

    task automatic add_point(int x, int y, logic start_new);
        point_t p;
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        p.start_new = start_new;
        point_queue.push_back(p);
        last_point = p;
    endtask

    // only while idle: all three registers, one per cycle
    task automatic set_circle(int cx, int cy, int r);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CENTER_X;
        cfg_data <= CFG_DATA_W'(cx);
        @(posedge clk);
        cfg_index <= CFG_CENTER_Y;
        cfg_data <= CFG_DATA_W'(cy);
        @(posedge clk);
        cfg_index <= CFG_RADIUS;
        cfg_data <= CFG_DATA_W'(r);
        @(posedge clk);
        cfg_we <= 1'b0;
        circle_cx = coord_t'(cx);
        circle_cy = coord_t'(cy);
        circle_r = radius_t'(r);
    endtask

    task automatic add_random_points(int count);
        int kind;
        int rad;
        int ox;
        int oy;
        logic st;
        for (int i = 0; i < count; i++)
        begin
            st = ($urandom_range(0, 99) < 6);
            kind = $urandom_range(0, 99);
            rad = int'(circle_r);
            if (kind < 10 && i > 0)
            begin
                // same point again: equal distance, store holds unless the start flag is set
                add_point(int'(last_point.x), int'(last_point.y), st);
            end
            else if (kind < 55)
            begin
                ox = int'($urandom_range(0, 2 * rad)) - rad;
                oy = rad - ((ox < 0) ? -ox : ox);
                if ($urandom_range(0, 1))
                    oy = -oy;
                ox += int'($urandom_range(0, 16)) - 8;
                oy += int'($urandom_range(0, 16)) - 8;
                add_point(int'(circle_cx) + ox, int'(circle_cy) + oy, st);
            end
            else if (kind < 80)
            begin
                add_point(int'(circle_cx) + int'($urandom_range(0, 512)) - 256,
                          int'(circle_cy) + int'($urandom_range(0, 512)) - 256, st);
            end
            else
            begin
                add_point(int'($urandom), int'($urandom), st);
            end
        end
    endtask

    task automatic drain();
        while (point_queue.size() != 0 || point_in.valid)
            @(posedge clk);
        while (best_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // point source
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            point_in.valid <= 1'b0;
            point_in.point_x <= '0;
            point_in.point_y <= '0;
            point_in.start_new <= 1'b0;
            send_gap_left <= 0;
        end
        else if (!point_in.valid || point_in.ready)
        begin
            if (send_gap_left != 0)
            begin
                point_in.valid <= 1'b0;
                send_gap_left <= send_gap_left - 1;
            end
            else if (point_queue.size() != 0)
            begin
                next_point = point_queue.pop_front();
                point_in.valid <= 1'b1;
                point_in.point_x <= next_point.x;
                point_in.point_y <= next_point.y;
                point_in.start_new <= next_point.start_new;
                send_gap_left <= send_gap();
            end
            else
            begin
                point_in.valid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            best_out.ready <= 1'b0;
            sink_hold_left <= 0;
        end
        else if (sink_hold_left != 0)
        begin
            best_out.ready <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end
        else
        begin
            automatic int n = sink_stall();
            best_out.ready <= (n == 0);
            sink_hold_left <= (n == 0) ? 0 : n - 1;
        end
    end

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_in.valid && point_in.ready)
            begin
                next_point.x = point_in.point_x;
                next_point.y = point_in.point_y;
                next_point.start_new = point_in.start_new;
                best_expected.push_back(judge_point(next_point));
            end
            if (best_out.valid && best_out.ready)
            begin
                if (best_expected.size() == 0)
                begin
                    $error("result with nothing pending: best_x %0d best_y %0d",
                           best_out.best_x, best_out.best_y);
                    error_count++;
                end
                else
                begin
                    want = best_expected.pop_front();
                    if (best_out.best_x !== want.x)
                    begin
                        $error("best_x expected %0d got %0d", want.x, best_out.best_x);
                        error_count++;
                    end
                    if (best_out.best_y !== want.y)
                    begin
                        $error("best_y expected %0d got %0d", want.y, best_out.best_y);
                        error_count++;
                    end
                    if (best_out.best_distance !== want.distance)
                    begin
                        $error("best_distance expected %0d got %0d",
                               want.distance, best_out.best_distance);
                        error_count++;
                    end
                    if (best_out.replaced !== want.replaced)
                    begin
                        $error("replaced expected %0b got %0b",
                               want.replaced, best_out.replaced);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nearest_point_to_circle verification failed");
            $finish;
        end
    end

    initial
    begin
        point_in.valid = 1'b0;
        point_in.point_x = '0;
        point_in.point_y = '0;
        point_in.start_new = 1'b0;
        best_out.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: center 0,0 radius 48
        add_point(0, 0, 1'b0);          // empty store after reset
        add_point(48, 0, 1'b0);         // on the circle
        add_point(0, 48, 1'b0);         // equal distance, kept
        add_point(-48, 0, 1'b0);
        add_point(0, -48, 1'b1);        // start flag forces a take
        add_point(32767, 32767, 1'b0);
        add_point(-32768, -32768, 1'b1);
        add_point(-32768, 32767, 1'b0);
        add_point(32767, -32768, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(1, -1, 1'b0);
        add_point(49, 0, 1'b0);
        add_point(47, 0, 1'b0);
        drain();

        set_circle(-32768, -32768, 65535);
        add_point(32767, 32767, 1'b1);  // largest spread
        add_point(-32768, -32768, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(-32768, 32767, 1'b0);
        drain();

        set_circle(32767, 32767, 0);
        add_point(-32768, -32768, 1'b1);
        add_point(32767, 32767, 1'b0);
        add_point(32767, 32767, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            quiet_phase = (ph == 3);
            case (ph)
                0: set_circle(int'($urandom), int'($urandom), 0);
                1: set_circle(int'($urandom), int'($urandom), 65535);
                2: set_circle(int'($urandom_range(0, 8000)) - 4000,
                              int'($urandom_range(0, 8000)) - 4000, 48);
                default: set_circle(int'($urandom_range(0, 8000)) - 4000,
                                    int'($urandom_range(0, 8000)) - 4000,
                                    $urandom_range(0, 4000));
            endcase
            add_random_points(150);
            drain();
        end

        if (error_count == 0 && best_expected.size() == 0)
            $display("nearest_point_to_circle verification clean");
        else
            $display("nearest_point_to_circle verification failed");
        $finish;
    end

endmodule
